// ===== sv/u16u8_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package u16u8_pkg;

    localparam logic [15:0] BUF_SIZE_RST = 16'hFFFF;
    localparam logic [5:0]  SURR_HI_TAG  = 6'b110110;
    localparam logic [5:0]  SURR_LO_TAG  = 6'b110111;
    localparam logic [20:0] SUPP_BASE    = 21'h10000;
    localparam int          MAX_RECS     = 3;

    typedef enum logic [1:0] {
        LEN_1 = 2'd0,
        LEN_2 = 2'd1,
        LEN_3 = 2'd2,
        LEN_4 = 2'd3
    } t_len;

    typedef struct packed {
        logic [7:0]  low_half;
        logic        have_low_half;
        logic [15:0] held_high;
        logic        high_pending;
        logic [15:0] bytes_written;
        logic        buffer_full;
        logic [31:0] utf8_total;
    } t_stream;

    typedef struct packed {
        logic [20:0] cp;
        t_len        len;
    } t_rec;

    typedef struct packed {
        logic [1:0]              nrec;
        t_rec [MAX_RECS-1:0]     rec;
        logic                    nul;
        logic [15:0]             wc;
        logic [31:0]             total;
        logic                    odd;
    } t_batch;

    function automatic t_len cp_len(input logic [20:0] cp);
        t_len l;
        if (cp < 21'h80) begin
            l = LEN_1;
        end else if (cp < 21'h800) begin
            l = LEN_2;
        end else if (cp < SUPP_BASE) begin
            l = LEN_3;
        end else begin
            l = LEN_4;
        end
        return l;
    endfunction

    function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input t_len len,
                                             input logic [1:0] k);
        logic [7:0] b;
        b = '0;
        case (len)
            LEN_1: begin
                b = {1'b0, cp[6:0]};
            end
            LEN_2: begin
                b = (k == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
            end
            LEN_3: begin
                case (k)
                    2'd0:    b = {4'b1110, cp[15:12]};
                    2'd1:    b = {2'b10, cp[11:6]};
                    default: b = {2'b10, cp[5:0]};
                endcase
            end
            default: begin
                case (k)
                    2'd0:    b = {5'b11110, cp[20:18]};
                    2'd1:    b = {2'b10, cp[17:12]};
                    2'd2:    b = {2'b10, cp[11:6]};
                    default: b = {2'b10, cp[5:0]};
                endcase
            end
        endcase
        return b;
    endfunction

endpackage
`default_nettype wire

// ===== sv/u16u8_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface u16u8_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;
    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface u16u8_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        is_terminator;
    logic        end_of_run;
    logic [15:0] written_count;
    logic [31:0] total_length;
    logic        odd_error;
    modport source (output valid, output out_byte, output is_terminator, output end_of_run,
                    output written_count, output total_length, output odd_error,
                    input ready);
    modport sink (input valid, input out_byte, input is_terminator, input end_of_run,
                  input written_count, input total_length, input odd_error,
                  output ready);
endinterface

interface u16u8_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] buf_size;
    modport source (output valid, output buf_size, input ready);
    modport sink (input valid, input buf_size, output ready);
endinterface
`default_nettype wire

// ===== sv/u16u8_step.sv =====
`timescale 1ns / 1ps
`default_nettype none
module u16u8_step
    import u16u8_pkg::*;
(
    input  t_stream     i_st,
    input  logic [7:0]  i_byte,
    input  logic        i_last,
    input  logic [15:0] i_buf_size,
    output t_stream     o_st,
    output t_batch      o_batch,
    output logic        o_any
);

    logic [15:0] eff;
    logic        second;
    logic [15:0] unit;
    logic        is_lo;
    logic        is_hi;
    logic [20:0] joined;
    logic        done;
    logic [15:0] held1;
    logic        hp1;
    logic        v [MAX_RECS];
    logic [20:0] cp [MAX_RECS];
    logic [15:0] bw;
    logic        full;
    logic [31:0] tot;
    logic [1:0]  cnt;
    t_len        len;
    logic [2:0]  nbytes;
    logic [15:0] wc;

    always_comb begin
        eff    = (i_buf_size == '0) ? 16'd1 : i_buf_size;
        second = i_st.have_low_half;
        unit   = {i_byte, i_st.low_half};
        is_lo  = (unit[15:10] == SURR_LO_TAG);
        is_hi  = (unit[15:10] == SURR_HI_TAG);
        joined = {1'b0, i_st.held_high[9:0], unit[9:0]} + SUPP_BASE;

        // held surrogate: joined with a low partner or sent alone
        v[0]  = second && i_st.high_pending;
        cp[0] = is_lo ? joined : {5'd0, i_st.held_high};
        done  = v[0] && is_lo;
        v[1]  = second && !done && !is_hi;
        cp[1] = {5'd0, unit};
        held1 = (second && !done && is_hi) ? unit : i_st.held_high;
        hp1   = second ? (!done && is_hi) : i_st.high_pending;
        // flush at end of string
        v[2]  = i_last && hp1;
        cp[2] = {5'd0, held1};

        bw      = i_st.bytes_written;
        full    = i_st.buffer_full;
        tot     = i_st.utf8_total;
        cnt     = '0;
        len     = LEN_1;
        nbytes  = '0;
        o_batch = '0;
        for (int i = 0; i < MAX_RECS; i++) begin
            len    = cp_len(cp[i]);
            nbytes = {1'b0, len} + 3'd1;
            if (v[i]) begin
                tot = tot + 32'(nbytes);
                if (!full) begin
                    if ({1'b0, bw} + 17'(nbytes) >= {1'b0, eff}) begin
                        full = 1'b1;
                    end else begin
                        o_batch.rec[cnt].cp  = cp[i];
                        o_batch.rec[cnt].len = len;
                        cnt = cnt + 2'd1;
                        bw  = bw + 16'(nbytes);
                    end
                end
            end
        end

        wc            = (bw >= eff) ? eff - 16'd1 : bw;
        o_batch.nrec  = cnt;
        o_batch.nul   = i_last;
        o_batch.wc    = wc + 16'd1;
        o_batch.total = tot;
        o_batch.odd   = !second;
        o_any         = (cnt != '0) || i_last;

        if (i_last) begin
            o_st = '0;
        end else begin
            o_st.low_half      = second ? i_st.low_half : i_byte;
            o_st.have_low_half = !second;
            o_st.held_high     = held1;
            o_st.high_pending  = hp1;
            o_st.bytes_written = bw;
            o_st.buffer_full   = full;
            o_st.utf8_total    = tot;
        end
    end

endmodule
`default_nettype wire

// ===== sv/utf16le_to_utf8_transcoder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// UTF-16LE to UTF-8 transcoder. Takes one string byte per word on i_in, low byte of each
// unit first, last_byte on the final byte; emits one UTF-8 byte per word on o_out and closes
// every string with a NUL word carrying written_count, total_length and odd_error. A byte is
// decoded in the cycle it is accepted into a batch register of up to three code points plus
// the NUL; an output sequencer then sends one byte per cycle into the output register while
// the output is not stalled. Input bytes are therefore paced by the output path; bytes that
// produce nothing are taken one per cycle while the sequencer is idle. The next byte is taken
// in the cycle the last byte of the current batch moves to the output register. The user must
// write buf_size on i_cfg only between strings; the block itself does not enforce this.
module utf16le_to_utf8_transcoder
    import u16u8_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    u16u8_cfg_if.sink           i_cfg,
    u16u8_in_if.sink            i_in,
    u16u8_out_if.source         o_out
);

    logic [15:0] r_buf_size;
    t_stream     r_st;
    t_stream     n_st;
    t_batch      r_batch;
    t_batch      n_batch;
    logic        w_any;
    logic        r_busy;
    logic        n_busy;
    logic [1:0]  r_ri;
    logic [1:0]  n_ri;
    logic [1:0]  r_k;
    logic [1:0]  n_k;
    t_rec        w_cur;
    logic        w_on_nul;
    logic        w_rec_end;
    logic        w_final;
    logic        w_move;
    logic        w_in_acc;

    logic        r_oval;
    logic [7:0]  r_obyte;
    logic        r_oterm;
    logic        r_oeor;
    logic [15:0] r_owc;
    logic [31:0] r_ototal;
    logic        r_oodd;
    logic [7:0]  n_obyte;
    logic        n_oeor;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf_size <= BUF_SIZE_RST;
        end else if (i_cfg.valid) begin
            r_buf_size <= i_cfg.buf_size;
        end
    end

    u16u8_step u_step (
        .i_st       (r_st),
        .i_byte     (i_in.data_byte),
        .i_last     (i_in.last_byte),
        .i_buf_size (r_buf_size),
        .o_st       (n_st),
        .o_batch    (n_batch),
        .o_any      (w_any)
    );

    always_comb begin
        case (r_ri)
            2'd0:    w_cur = r_batch.rec[0];
            2'd1:    w_cur = r_batch.rec[1];
            2'd2:    w_cur = r_batch.rec[2];
            default: w_cur = '0;
        endcase
    end

    assign w_on_nul  = (r_ri == r_batch.nrec);
    assign w_rec_end = (r_k == w_cur.len);
    assign w_final   = w_on_nul ||
                       (w_rec_end && (r_ri == r_batch.nrec - 2'd1) && !r_batch.nul);
    assign w_move    = r_busy && (!r_oval || o_out.ready);
    assign i_in.ready = !r_busy || (w_move && w_final);
    assign w_in_acc  = i_in.valid && i_in.ready;

    always_comb begin
        n_busy = r_busy;
        n_ri   = r_ri;
        n_k    = r_k;
        if (w_move) begin
            if (w_final) begin
                n_busy = 1'b0;
            end else if (w_rec_end) begin
                n_ri = r_ri + 2'd1;
                n_k  = '0;
            end else begin
                n_k = r_k + 2'd1;
            end
        end
        if (w_in_acc && w_any) begin
            n_busy = 1'b1;
            n_ri   = '0;
            n_k    = '0;
        end
    end

    always_comb begin
        n_obyte = w_on_nul ? 8'd0 : utf8_byte(w_cur.cp, w_cur.len, r_k);
        n_oeor  = w_final;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= '0;
            r_busy <= 1'b0;
            r_ri   <= '0;
            r_k    <= '0;
            r_oval <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_st <= n_st;
            end
            r_busy <= n_busy;
            r_ri   <= n_ri;
            r_k    <= n_k;
            if (w_move) begin
                r_oval <= 1'b1;
            end else if (o_out.ready) begin
                r_oval <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_any) begin
            r_batch <= n_batch;
        end
        if (w_move) begin
            r_obyte  <= n_obyte;
            r_oterm  <= w_on_nul;
            r_oeor   <= n_oeor;
            r_owc    <= w_on_nul ? r_batch.wc : 16'd0;
            r_ototal <= w_on_nul ? r_batch.total : 32'd0;
            r_oodd   <= w_on_nul && r_batch.odd;
        end
    end

    assign o_out.valid         = r_oval;
    assign o_out.out_byte      = r_obyte;
    assign o_out.is_terminator = r_oterm;
    assign o_out.end_of_run    = r_oeor;
    assign o_out.written_count = r_owc;
    assign o_out.total_length  = r_ototal;
    assign o_out.odd_error     = r_oodd;

    a_term_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.is_terminator |-> o_out.end_of_run && o_out.out_byte == 8'd0)
        else $error("terminator word without end of run");

    a_counts_only_on_term: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.is_terminator |->
            o_out.written_count == 16'd0 && o_out.total_length == 32'd0 && !o_out.odd_error)
        else $error("counts on data word");

    a_index_in_batch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_ri <= r_batch.nrec)
        else $error("record index past batch");

    a_idle_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !r_busy && !r_oval)
        else $error("busy after reset");

    a_nul_clears_stream: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && i_in.last_byte |=> r_st == '0)
        else $error("stream state kept after end of string");

endmodule
`default_nettype wire
